@@ sv/itp_pkg.sv @@
// Shared types, character codes and helpers for the integer text parser.
package itp_pkg;

    // Parse phase of the string under way
    typedef enum logic [2:0] {
        PH_START,   // first character, sign allowed in signed mode
        PH_NUM,     // number starts here (after a sign)
        PH_ZERO,    // a leading zero has been taken
        PH_ZX,      // leading "0x" seen, hex digit still to confirm
        PH_DIGITS,  // accumulating digits in the active base
        PH_SUF1,    // size letter seen, 'i' may follow
        PH_SUF2,    // "i" seen after the size letter, 'B' may follow
        PH_DONE     // parse finished, swallow the rest of the string
    } t_phase;

    typedef logic [1:0] t_mode;

    localparam t_mode MODE_SIGNED = 2'd1;
    localparam t_mode MODE_SUFFIX = 2'd2;

    // Register select, taken from paddr[2]
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_MODE = 1'b1;

    // Size suffix steps: one step is a factor of 1024
    typedef logic [1:0] t_sfx;
    localparam t_sfx SFX_NONE = 2'd0;
    localparam t_sfx SFX_KIB  = 2'd1;
    localparam t_sfx SFX_MIB  = 2'd2;
    localparam t_sfx SFX_GIB  = 2'd3;
    localparam int   KIB_SHIFT = 10;

    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
    localparam logic [7:0] CH_UG    = 8'h47;  // 'G'
    localparam logic [7:0] CH_UM    = 8'h4D;  // 'M'
    localparam logic [7:0] CH_UK    = 8'h4B;  // 'K'
    localparam logic [7:0] CH_LK    = 8'h6B;  // 'k'
    localparam logic [7:0] CH_LI    = 8'h69;  // 'i'
    localparam logic [7:0] CH_UB    = 8'h42;  // 'B'

    // Hex digit decode: bit 4 flags a hex digit, bits 3:0 give its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

endpackage

@@ sv/integer_text_parser.sv @@
// Integer text parser: one character per beat, one result per string.
// The last beat's parse is registered in stage 1, then scaled and negated into the output stage.
// Throughput: one character beat per cycle while o_stall is low, set by the single digit step
// (accumulator times base plus digit) between the parse registers.
// o_stall rises only while a finished result waits behind a stalled output.
// Reset (synchronous, active low) clears the parse, both config registers and the result valid flags.
module integer_text_parser
    import itp_pkg::*;
#(
    parameter int MAX_LENGTH = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Character channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value,
    output logic [7:0]  o_consumed,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Position counter must hold MAX_LENGTH itself
    localparam int PW = $clog2(MAX_LENGTH + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_LENGTH);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [4:0] r_base_sel;
    t_mode      r_mode;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_sel <= 5'd0;
            r_mode     <= 2'd0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_BASE: r_base_sel <= pwdata[4:0];
                REG_MODE: r_mode     <= pwdata[1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BASE: prdata = {27'd0, r_base_sel};
            REG_MODE: prdata = {30'd0, r_mode};
        endcase
    end

    // ---------------------------------------------------------------
    // Parse state, updated once per accepted character beat
    // ---------------------------------------------------------------
    t_phase        r_phase, n_phase;
    logic [63:0]   r_acc,   n_acc;
    logic [4:0]    r_base,  n_base;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_end,   n_end;
    logic          r_neg,   n_neg;
    t_sfx          r_shift, n_shift;

    logic          in_acc;      // character beat taken this cycle
    logic          s1_load;     // last beat taken: hand the parse to stage 1
    logic [7:0]    c;           // effective character
    logic [4:0]    hx;
    logic          is_hex;
    logic [3:0]    dval;
    logic [PW-1:0] idx_next;
    logic [4:0]    start_base;
    logic          start_digit;
    logic          run_digit;
    logic          lead_minus;
    logic          sfx_hit;
    t_sfx          sfx_code;
    logic [63:0]   prod;

    // Characters beyond the maximum length read as string end
    assign c        = (r_pos < MAX_POS) ? i_ch : CH_NUL;
    assign hx       = hex_decode(c);
    assign is_hex   = hx[4];
    assign dval     = hx[3:0];
    assign idx_next = r_pos + PW'(1);

    // Base in force where the number begins: octal after a lone leading zero
    assign start_base = (r_base_sel != 5'd0) ? r_base_sel :
                        (r_phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
    assign start_digit = is_hex && ({1'b0, dval} < start_base);
    assign run_digit   = is_hex && ({1'b0, dval} < r_base);
    assign lead_minus  = (r_phase == PH_START) && (r_mode == MODE_SIGNED)
                         && (c == CH_MINUS);
    assign prod        = r_acc * 64'(r_base);

    // Size letter right after the digits; lowercase m and g do not count
    always_comb begin
        unique case (c)
            CH_UG:        sfx_code = SFX_GIB;
            CH_UM:        sfx_code = SFX_MIB;
            CH_UK, CH_LK: sfx_code = SFX_KIB;
            default:      sfx_code = SFX_NONE;
        endcase
    end
    assign sfx_hit = (r_mode == MODE_SUFFIX) && (sfx_code != SFX_NONE);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_START, PH_NUM: begin
                if (lead_minus) begin
                    n_phase = PH_NUM;
                end else if (c == CH_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (start_digit) begin
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = sfx_hit ? PH_SUF1 : PH_DONE;
                end
            end
            PH_ZERO: begin
                if (c == CH_LX) begin
                    n_phase = PH_ZX;
                end else if (start_digit) begin
                    n_phase = PH_DIGITS;
                end else begin
                    n_phase = sfx_hit ? PH_SUF1 : PH_DONE;
                end
            end
            PH_ZX:     n_phase = is_hex ? PH_DIGITS : PH_DONE;
            PH_DIGITS: begin
                if (!run_digit) begin
                    n_phase = sfx_hit ? PH_SUF1 : PH_DONE;
                end
            end
            PH_SUF1:   n_phase = (c == CH_LI) ? PH_SUF2 : PH_DONE;
            PH_SUF2:   n_phase = PH_DONE;
            PH_DONE:   n_phase = PH_DONE;
        endcase
    end

    // Next accumulator, base, end position, sign and suffix
    always_comb begin
        n_acc   = r_acc;
        n_base  = r_base;
        n_end   = r_end;
        n_neg   = r_neg;
        n_shift = r_shift;
        unique case (r_phase)
            PH_START, PH_NUM, PH_ZERO: begin
                if (lead_minus) begin
                    n_neg = 1'b1;
                    n_end = idx_next;
                end else if (r_phase != PH_ZERO && c == CH_ZERO) begin
                    n_end = idx_next;
                end else if (r_phase == PH_ZERO && c == CH_LX) begin
                    // hold: only the zero counts until a hex digit confirms
                end else if (start_digit) begin
                    n_acc  = {60'd0, dval};
                    n_base = start_base;
                    n_end  = idx_next;
                end else if (sfx_hit) begin
                    n_shift = sfx_code;
                end
            end
            PH_ZX: begin
                if (is_hex) begin
                    n_acc  = {60'd0, dval};
                    n_base = BASE_HEX;
                    n_end  = idx_next;
                end
            end
            PH_DIGITS: begin
                if (run_digit) begin
                    n_acc = prod + {60'd0, dval};
                    n_end = idx_next;
                end else if (sfx_hit) begin
                    n_shift = sfx_code;
                end
            end
            PH_SUF1: begin
                // The size letter and its 'i' both count once the 'i' is seen
                if (c == CH_LI) begin
                    n_end = idx_next;
                end
            end
            PH_SUF2: begin
                if (c == CH_UB) begin
                    n_end = idx_next;
                end
            end
            PH_DONE: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result stages: stage 1 holds the raw parse, stage 2 scales/negates
    // ---------------------------------------------------------------
    logic          r_s1_vld;
    logic [63:0]   r_s1_acc;
    logic          r_s1_neg;
    t_sfx          r_s1_shift;
    logic [PW-1:0] r_s1_end;
    logic          s2_en;

    logic          r_out_vld;
    logic [63:0]   r_out_value;
    logic [7:0]    r_out_consumed;

    logic [63:0]   scaled;
    logic [31:0]   end_wide;

    assign s2_en   = !r_out_vld || !i_stall;
    assign o_stall = r_s1_vld && !s2_en;
    assign in_acc  = i_valid && !o_stall;
    assign s1_load = in_acc && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= 64'd0;
            r_base  <= 5'd0;
            r_pos   <= '0;
            r_end   <= '0;
            r_neg   <= 1'b0;
            r_shift <= SFX_NONE;
        end else if (s1_load) begin
            // String closes: start afresh for the next one
            r_phase <= PH_START;
            r_acc   <= 64'd0;
            r_pos   <= '0;
            r_end   <= '0;
            r_neg   <= 1'b0;
            r_shift <= SFX_NONE;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_end   <= n_end;
            r_neg   <= n_neg;
            r_shift <= n_shift;
            if (r_pos < MAX_POS) begin
                r_pos <= idx_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_load) begin
            r_s1_vld <= 1'b1;
        end else if (s2_en) begin
            r_s1_vld <= 1'b0;
        end
    end

    // The string end after the last character stops any parse in flight,
    // so the values after this beat are final
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_acc   <= n_acc;
            r_s1_neg   <= n_neg;
            r_s1_shift <= n_shift;
            r_s1_end   <= n_end;
        end
    end

    always_comb begin
        unique case (r_s1_shift)
            SFX_NONE: scaled = r_s1_acc;
            SFX_KIB:  scaled = r_s1_acc << KIB_SHIFT;
            SFX_MIB:  scaled = r_s1_acc << (2 * KIB_SHIFT);
            SFX_GIB:  scaled = r_s1_acc << (3 * KIB_SHIFT);
        endcase
    end
    assign end_wide = 32'(r_s1_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_en) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en && r_s1_vld) begin
            r_out_value    <= r_s1_neg ? (64'd0 - scaled) : scaled;
            // Saturate the consumed count at the byte limit
            r_out_consumed <= (end_wide > 32'd255) ? 8'hFF : end_wide[7:0];
        end
    end

    assign o_valid    = r_out_vld;
    assign o_value    = r_out_value;
    assign o_consumed = r_out_consumed;

endmodule

@@ sv/itp_checker.sv @@
// Port-level checker for the integer text parser, bound to the top level.
module itp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_value,
    input logic [7:0]  o_consumed
);

    // Reset empties both result stages
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result stages not empty after reset");

    // Input back-pressure only when a result sits stalled on the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // A fresh result traces back to a taken last beat, registered in stage 1 and then the output stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && i_last && !o_stall, 2))
        else $error("result without a last beat");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_consumed))
        else $error("stalled result beat changed");

endmodule

bind integer_text_parser itp_checker u_itp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_last     (i_last),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_value    (o_value),
    .o_consumed (o_consumed)
);
